### hw/rtl/lcdsw_pkg.sv
// Shared types and constants for the three-wire LCD serial frame writer.
// No dependencies; imported by the controller, the datapath and the top level.
package lcdsw_pkg;

  // Frame layout constants.
  localparam logic [3:0] CMD_PREFIX  = 4'b1000;
  localparam logic [2:0] DATA_HEADER = 3'b101;
  localparam int unsigned SHIFT_W    = 17;
  localparam int unsigned COUNT_W    = 5;
  localparam logic [COUNT_W-1:0] CMD_BITS   = 5'd12;
  localparam logic [COUNT_W-1:0] OPEN_BITS  = 5'd17;
  localparam logic [COUNT_W-1:0] DATA_BITS  = 5'd8;

  // Action codes of a request.
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_DATA    = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] value;
    logic [5:0] address;
    logic       first_of_burst;
    logic       last_of_burst;
  } req_t;

  typedef struct packed {
    logic data_bit;
    logic select_fall;
    logic select_rise;
    logic last_bit;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEND
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic shift;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic final_bit;
  } dp_status_t;

endpackage

### hw/rtl/lcdsw_datapath.sv
// Shift register and bit counter that serialize one request into its bits.
// Depends on lcdsw_pkg.
module lcdsw_datapath
  import lcdsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output rsp_t       rsp
);

  logic [SHIFT_W-1:0] shreg;
  logic [COUNT_W-1:0] remain;
  logic               fall_pend;
  logic               rise_flag;
  logic               final_bit;

  assign final_bit = (remain == COUNT_W'(1));

  // Bit counter is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (cmd.load) begin
      if (req.action == ACT_COMMAND) begin
        remain <= CMD_BITS;
      end else if (req.first_of_burst) begin
        remain <= OPEN_BITS;
      end else begin
        remain <= DATA_BITS;
      end
    end else if (cmd.shift) begin
      remain <= remain - COUNT_W'(1);
    end
  end

  // The frame is left aligned so the next bit is always the top bit.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (req.action == ACT_COMMAND) begin
        shreg     <= {CMD_PREFIX, req.value, 5'b0};
        fall_pend <= 1'b1;
        rise_flag <= 1'b1;
      end else if (req.first_of_burst) begin
        shreg     <= {DATA_HEADER, req.address, req.value};
        fall_pend <= 1'b1;
        rise_flag <= req.last_of_burst;
      end else begin
        shreg     <= {req.value, 9'b0};
        fall_pend <= 1'b0;
        rise_flag <= req.last_of_burst;
      end
    end else if (cmd.shift) begin
      shreg     <= {shreg[SHIFT_W-2:0], 1'b0};
      fall_pend <= 1'b0;
    end
  end

  // Result fields come straight from the registers, so they hold while stalled.
  assign rsp.data_bit    = shreg[SHIFT_W-1];
  assign rsp.select_fall = fall_pend;
  assign rsp.select_rise = rise_flag & final_bit;
  assign rsp.last_bit    = final_bit;

  assign status.final_bit = final_bit;

endmodule

### hw/rtl/lcdsw_controller.sv
// Controller state machine that loads a request and steps through its bits.
// Depends on lcdsw_pkg.
module lcdsw_controller
  import lcdsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SEND;
        end
      end
      ST_SEND: begin
        if (!rsp_stall && status.final_bit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    cmd       = '0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_SEND: begin
        rsp_valid = 1'b1;
        cmd.shift = !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

### hw/rtl/lcd_controller_serial_frame_writer.sv
// Top level of the three-wire LCD serial frame writer.
// Depends on lcdsw_pkg, lcdsw_controller and lcdsw_datapath.
//
// Each request turns into one result per serial bit, most significant bit
// first: 12 bits for a command, 17 for a data byte that opens a burst and 8
// for any other data byte. Bits leave at one per cycle from a shift register
// while the result side does not stall. A new request is taken only once
// the last bit of the previous one has been delivered.
module lcd_controller_serial_frame_writer
  import lcdsw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lcdsw_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  lcdsw_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

  // No request is taken while a bit is being offered.
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request accepted while a frame is in progress");

  // The last bit of a request ends the run of results.
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && rsp.last_bit) |=> !rsp_valid)
    else $error("results continue after the last bit");

  // Chip select rises only on the final bit.
  a_rise_on_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.select_rise) |-> rsp.last_bit)
    else $error("select rise flagged before the last bit");

  // The first bit carries the select fall exactly when the frame opens.
  a_first_fall: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=>
      (rsp_valid && (rsp.select_fall ==
        ($past(req.action) == ACT_COMMAND || $past(req.first_of_burst)))))
    else $error("select fall flag wrong on first bit");

endmodule

### bench/testbench.sv
// Self-checking testbench for the three-wire LCD serial frame writer.
// Depends on lcdsw_pkg and the lcd_controller_serial_frame_writer top level.
// A queue-fed driver sends requests, and a monitor checks every serial bit.
module testbench
  import lcdsw_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Frame layout as the serial protocol defines it.
  localparam logic [3:0] COMMAND_PREFIX = 4'b1000;
  localparam logic [2:0] BURST_HEADER   = 3'b101;
  localparam int         IDLE_PERCENT   = 21;
  localparam int         RANDOM_ITEMS   = 86;
  localparam int         STALL_LIMIT    = 1000;
  localparam int         TAIL_CYCLES    = 40;

  typedef struct {
    req_t item;
    bit   drain;
  } pending_req_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_req_t pending_reqs[$];
  rsp_t         expected_bits[$];

  int unsigned sent_count     = 0;
  int unsigned command_count  = 0;
  int unsigned burst_count    = 0;
  int unsigned data_count     = 0;
  int unsigned bits_checked   = 0;
  int unsigned error_count    = 0;
  int unsigned quiet_cycles   = 0;
  bit          tail_done      = 1'b0;

  lcd_controller_serial_frame_writer uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Expands one accepted request into the serial bits it must produce.
  function automatic void predict_frame_bits(req_t r);
    logic [16:0] pattern;
    int          nbits;
    bit          fall;
    bit          rise;
    rsp_t        b;
    if (r.action == ACT_COMMAND) begin
      pattern = {COMMAND_PREFIX, r.value, 5'b0};
      nbits   = 12;
      fall    = 1'b1;
      rise    = 1'b1;
      command_count++;
    end else begin
      if (r.first_of_burst) begin
        pattern = {BURST_HEADER, r.address, r.value};
        nbits   = 17;
        burst_count++;
      end else begin
        pattern = {r.value, 9'b0};
        nbits   = 8;
      end
      fall = r.first_of_burst;
      rise = r.last_of_burst;
      data_count++;
    end
    for (int i = 0; i < nbits; i++) begin
      b.data_bit    = pattern[16-i];
      b.select_fall = (i == 0) && fall;
      b.select_rise = (i == nbits - 1) && rise;
      b.last_bit    = (i == nbits - 1);
      expected_bits.push_back(b);
    end
  endfunction

  task automatic add_req(logic action, logic [7:0] value, logic [5:0] address,
                         logic first, logic last, bit drain = 1'b0);
    pending_req_t p;
    p.item.action         = action;
    p.item.value          = value;
    p.item.address        = address;
    p.item.first_of_burst = first;
    p.item.last_of_burst  = last;
    p.drain               = drain;
    pending_reqs.push_back(p);
  endtask

  // No idling on either side through a stretch in the middle of the run.
  function automatic bit idle_now();
    if (sent_count >= 40 && sent_count < 70) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PERCENT;
  endfunction

  // Request driver: holds a stalled request, otherwise presents the next one or idles.
  always @(posedge clk) begin
    bit hold;
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      hold = req_valid && req_stall;
      if (req_valid && !req_stall) begin
        predict_frame_bits(req);
        sent_count++;
      end
      if (!hold) begin
        if (pending_reqs.size() == 0) begin
          req_valid <= 1'b0;
        end else if (pending_reqs[0].drain && expected_bits.size() != 0) begin
          req_valid <= 1'b0;
        end else if (idle_now()) begin
          req_valid <= 1'b0;
        end else begin
          req       <= pending_reqs[0].item;
          req_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end
      end
    end
  end

  // Result monitor: random stalls, and a field-by-field check of each bit.
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_bits.size() == 0) begin
          $error("unexpected serial bit: data_bit=%0b fall=%0b rise=%0b last=%0b",
                 rsp.data_bit, rsp.select_fall, rsp.select_rise, rsp.last_bit);
          error_count++;
        end else begin
          want = expected_bits.pop_front();
          bits_checked++;
          if (rsp.data_bit !== want.data_bit) begin
            $error("data_bit: expected %0b, actual %0b", want.data_bit, rsp.data_bit);
            error_count++;
          end
          if (rsp.select_fall !== want.select_fall) begin
            $error("select_fall: expected %0b, actual %0b",
                   want.select_fall, rsp.select_fall);
            error_count++;
          end
          if (rsp.select_rise !== want.select_rise) begin
            $error("select_rise: expected %0b, actual %0b",
                   want.select_rise, rsp.select_rise);
            error_count++;
          end
          if (rsp.last_bit !== want.last_bit) begin
            $error("last_bit: expected %0b, actual %0b", want.last_bit, rsp.last_bit);
            error_count++;
          end
        end
      end
      rsp_stall <= idle_now();
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (!rst && !tail_done) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without progress", quiet_cycles);
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int       kind;
    int       len;
    int       made;
    logic [5:0] addr;

    // Directed requests: field extremes and the framing corner cases.
    add_req(ACT_COMMAND, 8'h00, 6'h00, 1'b0, 1'b0);
    add_req(ACT_COMMAND, 8'hFF, 6'h3F, 1'b1, 1'b1);
    add_req(ACT_COMMAND, 8'hA5, 6'h15, 1'b1, 1'b0);
    // One-byte bursts at both address extremes.
    add_req(ACT_DATA, 8'h00, 6'h00, 1'b1, 1'b1);
    add_req(ACT_DATA, 8'hFF, 6'h3F, 1'b1, 1'b1);
    // A three-byte burst.
    add_req(ACT_DATA, 8'h5A, 6'h2A, 1'b1, 1'b0);
    add_req(ACT_DATA, 8'hC3, 6'h3F, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h3C, 6'h00, 1'b0, 1'b1);
    // A data byte outside any burst, then one that only closes.
    add_req(ACT_DATA, 8'h81, 6'h11, 1'b0, 1'b0);
    add_req(ACT_DATA, 8'h7E, 6'h2E, 1'b0, 1'b1);
    // A command in the middle of an open burst.
    add_req(ACT_DATA, 8'h96, 6'h01, 1'b1, 1'b0);
    add_req(ACT_COMMAND, 8'h29, 6'h3F, 1'b0, 1'b1);
    add_req(ACT_DATA, 8'h69, 6'h20, 1'b0, 1'b1);
    // Sender waits here until the block has drained.
    add_req(ACT_COMMAND, 8'h01, 6'h00, 1'b0, 1'b0, 1'b1);

    // Random part: mostly well-formed frames and bursts, some noise.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 9);
      if (kind <= 2) begin
        add_req(ACT_COMMAND, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), made == 50);
        made++;
      end else if (kind <= 7) begin
        len  = $urandom_range(1, 4);
        addr = 6'($urandom_range(0, 63));
        for (int i = 0; i < len; i++) begin
          add_req(ACT_DATA, 8'($urandom_range(0, 255)),
                  (i == 0) ? addr : 6'($urandom_range(0, 63)),
                  i == 0, i == len - 1, (i == 0) && (made >= 80) && (made < 84));
          made++;
        end
      end else begin
        add_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
        made++;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request is in and every bit has been checked.
    do begin
      @(posedge clk);
    end while (pending_reqs.size() != 0 || req_valid || expected_bits.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    tail_done = 1'b1;

    $display("covered %0d requests: %0d commands, %0d data bytes in %0d opened bursts",
             sent_count, command_count, data_count, burst_count);
    $display("checked %0d serial bits, %0d mismatches", bits_checked, error_count);
    if (error_count == 0 && expected_bits.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
